// File: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bse assertion failed");

// property checked on every rising edge, reset included
`define BSE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bse reset assertion failed");

`endif

// File: src/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared operation codes and types of the bitmap select engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // result of the byte unit: ones in the byte and offset of the k-th one
  typedef struct packed {
    logic [3:0] pop;
    logic [2:0] pos;
  } byte_res_t;

endpackage

`default_nettype wire

// File: src/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic [AW-1:0]          raddr,
  output      logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/bse_byte_unit.sv
// ----------------------------------------------------------------------------
// bse_byte_unit
// Counts the ones of one byte and locates its k-th one, msb first.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_byte_unit (
  input  wire logic [7:0]         byte_in,
  input  wire logic [3:0]         k,
  output      bse_pkg::byte_res_t res
);

  always_comb begin
    logic [3:0] seen;
    logic       got;
    seen    = 4'd0;
    got     = 1'b0;
    res.pos = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (byte_in[7-i]) begin
        seen = seen + 4'd1;
        if (!got && seen == k) begin
          res.pos = 3'(i);
          got     = 1'b1;
        end
      end
    end
    res.pop = seen;
  end

endmodule

`default_nettype wire

// File: src/bitmap_select_engine_core.sv
// ----------------------------------------------------------------------------
// bitmap_select_engine_core
// Stores appended 64-bit bitmap words and answers select queries on them.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries op, word_data and query_rank.
// Append stores a word and walks it one byte per cycle to record every
// 2^SKIP_BITS-th one bit in the sample RAM. Clear is handled in the idle
// state. A query reads its sample entry, then for each word it visits
// reads the word and walks it one byte per cycle (up to 8 bytes); a query
// with rank zero or above the total ones is answered from the idle state
// with status 1. All byte work goes through one shared byte unit and the
// word and sample RAMs have one read port each. One item is in work at a
// time; in_ready is high only while idle and the output register is free
// or being taken. The result sits in an output register
// (out_valid/out_ready) until taken. Reset empties the bitmap (count zero,
// no words, next sample one); RAM contents are not cleared and are never
// read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_select_engine_core #(
  parameter int WORD_DEPTH = 1024,
  parameter int SKIP_BITS  = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [63:0] word_data,
  input  wire logic [16:0] query_rank,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [15:0] bit_position,
  output      logic        status
);

  localparam int WI  = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
  localparam int LW  = $clog2(WORD_DEPTH + 1);
  localparam int PW  = WI + 6;
  localparam int OW  = PW + 1;
  localparam int SD  = ((WORD_DEPTH * 64) >> SKIP_BITS) + 1;
  localparam int SAW = $clog2(SD);
  localparam int SW  = $clog2(SD + 1);
  localparam int RW  = SKIP_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_APP   = 5'b00010,
    S_QSMP  = 5'b00100,
    S_QWR   = 5'b01000,
    S_QSCAN = 5'b10000
  } state_t;

  state_t         st, st_next;
  logic [LW-1:0]  words_loaded, words_loaded_next;
  logic [OW-1:0]  ones_total, ones_total_next;
  logic [SW-1:0]  next_sample, next_sample_next;
  logic [63:0]    wbuf, wbuf_next;
  logic [2:0]     bsel, bsel_next;
  logic [OW-1:0]  cnt, cnt_next;
  logic [RW-1:0]  rr, rr_next;
  logic [LW-1:0]  idx, idx_next;
  logic [5:0]     start, start_next;
  logic           slot0, slot0_next;
  logic           out_valid_next;
  logic [15:0]    bit_position_next;
  logic           status_next;

  logic           bm_we;
  logic [WI-1:0]  bm_raddr;
  logic [63:0]    bm_rdata;
  logic           sm_we;
  logic [SAW-1:0] sm_waddr;
  logic [OW-1:0]  sm_wdata;
  logic [SAW-1:0] sm_raddr;
  logic [OW-1:0]  sm_rdata;

  logic [7:0]          cur_byte;
  logic [3:0]          unit_k;
  bse_pkg::byte_res_t  ures;

  logic           out_free;
  logic           accept;
  logic [OW-1:0]  sum;
  logic [31:0]    tgt;
  logic           smp_hit;
  logic           q_hit;
  logic [OW-1:0]  s_val;
  logic [LW-1:0]  s_idx;
  logic [LW-1:0]  idx_inc;

  bse_ram #(.WIDTH(64), .DEPTH(WORD_DEPTH)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (words_loaded[WI-1:0]),
    .wdata (word_data),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  bse_ram #(.WIDTH(OW), .DEPTH(SD)) u_samples (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  bse_byte_unit u_byte (
    .byte_in (cur_byte),
    .k       (unit_k),
    .res     (ures)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (st == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // byte bsel of the word, msb first
  assign cur_byte = wbuf[63 - 8*bsel -: 8];
  assign sum      = cnt + OW'(ures.pop);
  assign tgt      = 32'(next_sample) << SKIP_BITS;
  assign smp_hit  = (32'(next_sample) < 32'(SD)) && (tgt <= 32'(sum));
  assign q_hit    = 32'(rr) <= 32'(ures.pop);
  assign unit_k   = (st == S_APP) ? 4'(tgt - 32'(cnt)) : 4'(rr);
  assign s_val    = slot0 ? '0 : sm_rdata;
  assign s_idx    = LW'(s_val[OW-1:6]);
  assign idx_inc  = idx + LW'(1);

  assign sm_raddr = SAW'(query_rank >> SKIP_BITS);
  assign sm_waddr = SAW'(next_sample);
  assign sm_wdata = OW'({words_loaded[WI-1:0], bsel, ures.pos}) + OW'(1);
  assign bm_raddr = (st == S_QSMP) ? s_idx[WI-1:0] : idx_inc[WI-1:0];

  always_comb begin
    st_next           = st;
    words_loaded_next = words_loaded;
    ones_total_next   = ones_total;
    next_sample_next  = next_sample;
    wbuf_next         = wbuf;
    bsel_next         = bsel;
    cnt_next          = cnt;
    rr_next           = rr;
    idx_next          = idx;
    start_next        = start;
    slot0_next        = slot0;
    out_valid_next    = out_valid && !out_ready;
    bit_position_next = bit_position;
    status_next       = status;
    bm_we             = 1'b0;
    sm_we             = 1'b0;

    unique case (st)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            bse_pkg::OP_APPEND: begin
              if (32'(words_loaded) < 32'(WORD_DEPTH)) begin
                bm_we     = 1'b1;
                wbuf_next = word_data;
                bsel_next = 3'd0;
                cnt_next  = ones_total;
                st_next   = S_APP;
              end
            end
            bse_pkg::OP_QUERY: begin
              if (query_rank == '0 || 32'(query_rank) > 32'(ones_total)) begin
                out_valid_next    = 1'b1;
                bit_position_next = '0;
                status_next       = 1'b1;
              end else begin
                rr_next    = RW'(query_rank);
                slot0_next = (query_rank >> SKIP_BITS) == '0;
                st_next    = S_QSMP;
              end
            end
            bse_pkg::OP_CLEAR: begin
              words_loaded_next = '0;
              ones_total_next   = '0;
              next_sample_next  = SW'(1);
            end
            default: begin
            end
          endcase
        end
      end
      S_APP: begin
        if (smp_hit) begin
          sm_we            = 1'b1;
          next_sample_next = next_sample + SW'(1);
        end
        cnt_next  = sum;
        bsel_next = bsel + 3'd1;
        if (bsel == 3'd7) begin
          words_loaded_next = words_loaded + LW'(1);
          ones_total_next   = sum;
          st_next           = S_IDLE;
        end
      end
      S_QSMP: begin
        // rank on a sample point: the sample itself is the answer
        if (rr == '0) begin
          out_valid_next    = 1'b1;
          bit_position_next = 16'(s_val - OW'(1));
          status_next       = 1'b0;
          st_next           = S_IDLE;
        end else if (s_idx >= words_loaded) begin
          out_valid_next    = 1'b1;
          bit_position_next = '0;
          status_next       = 1'b0;
          st_next           = S_IDLE;
        end else begin
          idx_next   = s_idx;
          start_next = s_val[5:0];
          st_next    = S_QWR;
        end
      end
      S_QWR: begin
        wbuf_next  = bm_rdata & ({64{1'b1}} >> start);
        start_next = 6'd0;
        bsel_next  = 3'd0;
        st_next    = S_QSCAN;
      end
      S_QSCAN: begin
        if (q_hit) begin
          out_valid_next    = 1'b1;
          bit_position_next = 16'({idx[WI-1:0], bsel, ures.pos});
          status_next       = 1'b0;
          st_next           = S_IDLE;
        end else begin
          rr_next   = rr - RW'(ures.pop);
          bsel_next = bsel + 3'd1;
          if (bsel == 3'd7) begin
            idx_next = idx_inc;
            if (idx_inc >= words_loaded) begin
              out_valid_next    = 1'b1;
              bit_position_next = '0;
              status_next       = 1'b0;
              st_next           = S_IDLE;
            end else begin
              st_next = S_QWR;
            end
          end
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      words_loaded <= '0;
      ones_total   <= '0;
      next_sample  <= SW'(1);
      out_valid    <= 1'b0;
    end else begin
      st           <= st_next;
      words_loaded <= words_loaded_next;
      ones_total   <= ones_total_next;
      next_sample  <= next_sample_next;
      out_valid    <= out_valid_next;
    end
    wbuf         <= wbuf_next;
    bsel         <= bsel_next;
    cnt          <= cnt_next;
    rr           <= rr_next;
    idx          <= idx_next;
    start        <= start_next;
    slot0        <= slot0_next;
    bit_position <= bit_position_next;
    status       <= status_next;
  end

endmodule

`default_nettype wire

// File: src/bse_checker.sv
// ----------------------------------------------------------------------------
// bse_checker
// Port level checks of the bitmap select engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  op,
  input wire logic [16:0] query_rank,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] bit_position,
  input wire logic        status
);

  logic rank0_acc;

  assign rank0_acc = in_valid && in_ready && op == bse_pkg::OP_QUERY && query_rank == 17'd0;

  // a stalled result holds
  `BSE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(bit_position))
  // an error result always carries position zero
  `BSE_ASSERT(a_err_zero, out_valid && status |-> bit_position == 16'd0)
  // rank zero is answered in the next cycle as an error
  `BSE_ASSERT(a_rank0, rank0_acc |=> out_valid && status)
  // nothing leaves right after reset
  `BSE_ASSERT_RST(a_rst_idle, rst |=> !out_valid)

endmodule

bind bitmap_select_engine_core bse_checker u_bse_checker (.*);

`default_nettype wire
